>>> sv/arrival_order_departure_gate_core_macros.svh
// assertion macros shared by the gate checker
`ifndef ARRIVAL_ORDER_DEPARTURE_GATE_CORE_MACROS_SVH
`define ARRIVAL_ORDER_DEPARTURE_GATE_CORE_MACROS_SVH

// same-cycle implication, off while reset is high
`define AODG_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gate assertion failed");

// next-cycle implication, off while reset is high
`define AODG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gate assertion failed");

// next-cycle implication that also runs through reset
`define AODG_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("gate assertion failed");

`endif

>>> sv/aodg_pkg.sv
// shared types and constants of the arrival order departure gate
package aodg_pkg;

   localparam int VID_BITS       = 16;
   localparam int POS_BITS       = 4;
   localparam int OCC_BITS       = 5;
   localparam int MIN_OCC_BITS   = 5;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_OCCUPANCY = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FIFO_MODE     = 8'd1;

   typedef enum logic [1:0] {
      CMD_ARRIVE = 2'd0,
      CMD_DEPART = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic load;
      logic search_step;
      logic shift_step;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic search_done;
      logic match;
      logic shift_done;
      logic is_depart;
      logic out_free;
   } dp_status_type;

endpackage

>>> sv/aodg_ram.sv
// generic single write port ram with registered read
module aodg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/aodg_dpath.sv
// datapath: id list memory, scan and compaction pointers, config and result registers
module aodg_dpath #(
   parameter int DEPTH   = 16,
   parameter int ID_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  aodg_pkg::dp_cmd_type                 dp_cmd,
   output aodg_pkg::dp_status_type              dp_status,
   input  aodg_pkg::cmd_type                    req_command,
   input  logic [aodg_pkg::VID_BITS-1:0]        req_vehicle_id,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [aodg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [aodg_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_allowed,
   output logic                                 rsp_found,
   output logic [aodg_pkg::POS_BITS-1:0]        rsp_position,
   output logic [aodg_pkg::OCC_BITS-1:0]        rsp_occupancy,
   output logic                                 rsp_dropped
);
   import aodg_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > MIN_OCC_BITS) ? CW : MIN_OCC_BITS;

   cmd_type                  cmd_ff, cmd_in;
   logic [ID_BITS-1:0]       vid_ff, vid_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            issue_ff, issue_in;
   logic                     pend_ff, pend_in;
   logic [AW-1:0]            pidx_ff, pidx_in;
   logic                     hit_ff, hit_in;
   logic [AW-1:0]            pos_ff, pos_in;
   logic [MIN_OCC_BITS-1:0]  min_occ_ff;
   logic                     fifo_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     allowed_ff, allowed_in;
   logic                     found_ff, found_in;
   logic [POS_BITS-1:0]      position_ff, position_in;
   logic [OCC_BITS-1:0]      occupancy_ff, occupancy_in;
   logic                     dropped_ff, dropped_in;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [ID_BITS-1:0]       wr_data;
   logic [ID_BITS-1:0]       rd_data;
   logic                     match;
   logic                     more;
   logic                     full;
   logic                     enough;

   aodg_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign match  = pend_ff && (rd_data == vid_ff);
   assign more   = issue_ff < count_ff;
   assign full   = count_ff == CW'(DEPTH);
   assign enough = CMPW'(count_ff) >= CMPW'(min_occ_ff);

   always_comb begin
      cmd_in       = cmd_ff;
      vid_in       = vid_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      wr_en        = 1'b0;
      wr_addr      = pidx_ff - AW'(1);
      wr_data      = rd_data;
      allowed_in   = allowed_ff;
      found_in     = found_ff;
      position_in  = position_ff;
      occupancy_in = occupancy_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (dp_cmd.load) begin
         cmd_in   = req_command;
         vid_in   = ID_BITS'(req_vehicle_id);
         issue_in = '0;
         pend_in  = 1'b0;
         hit_in   = 1'b0;
         pos_in   = '0;
      end

      if (dp_cmd.search_step) begin
         if (match) begin
            hit_in   = 1'b1;
            pos_in   = pidx_ff;
            // compaction starts reading just after the hit
            issue_in = CW'(pidx_ff) + CW'(1);
            pend_in  = 1'b0;
         end else if (more) begin
            pend_in  = 1'b1;
            pidx_in  = issue_ff[AW-1:0];
            issue_in = issue_ff + CW'(1);
         end else begin
            pend_in  = 1'b0;
         end
      end

      if (dp_cmd.shift_step) begin
         // entry read last cycle moves down one slot
         wr_en = pend_ff;
         if (more) begin
            pend_in  = 1'b1;
            pidx_in  = issue_ff[AW-1:0];
            issue_in = issue_ff + CW'(1);
         end else begin
            pend_in  = 1'b0;
         end
      end

      if (dp_cmd.finish) begin
         allowed_in   = 1'b0;
         dropped_in   = 1'b0;
         found_in     = hit_ff;
         position_in  = hit_ff ? POS_BITS'(pos_ff) : '0;
         unique case (cmd_ff)
            CMD_ARRIVE: begin
               if (vid_ff != '0 && !hit_ff) begin
                  if (full) begin
                     dropped_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     wr_data  = vid_ff;
                     count_in = count_ff + CW'(1);
                  end
               end
            end
            CMD_DEPART: begin
               if (hit_ff) begin
                  count_in = count_ff - CW'(1);
               end
            end
            CMD_QUERY: begin
               allowed_in = (min_occ_ff == '0) ||
                            (hit_ff && enough && (!fifo_ff || pos_ff == '0));
            end
            CMD_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
         occupancy_in = OCC_BITS'(count_in);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         min_occ_ff   <= '0;
         fifo_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_MIN_OCCUPANCY: min_occ_ff <= csr_wdata[MIN_OCC_BITS-1:0];
               REG_FIFO_MODE:     fifo_ff    <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      vid_ff       <= vid_in;
      issue_ff     <= issue_in;
      pidx_ff      <= pidx_in;
      hit_ff       <= hit_in;
      pos_ff       <= pos_in;
      allowed_ff   <= allowed_in;
      found_ff     <= found_in;
      position_ff  <= position_in;
      occupancy_ff <= occupancy_in;
      dropped_ff   <= dropped_in;
   end

   assign dp_status.search_done = match || !more;
   assign dp_status.match       = match;
   assign dp_status.shift_done  = !more;
   assign dp_status.is_depart   = cmd_ff == CMD_DEPART;
   assign dp_status.out_free    = !rsp_valid_ff || rsp_ready;

   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_allowed   = allowed_ff;
   assign rsp_found     = found_ff;
   assign rsp_position  = position_ff;
   assign rsp_occupancy = occupancy_ff;
   assign rsp_dropped   = dropped_ff;

endmodule

>>> sv/aodg_ctrl.sv
// controller: sequences accept, list scan, compaction and result load
module aodg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output aodg_pkg::dp_cmd_type    dp_cmd,
   input  aodg_pkg::dp_status_type dp_status
);
   import aodg_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_SHIFT  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in           = state_ff;
      dp_cmd.load        = 1'b0;
      dp_cmd.search_step = 1'b0;
      dp_cmd.shift_step  = 1'b0;
      dp_cmd.finish      = 1'b0;
      req_ready          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            dp_cmd.load = req_valid;
            if (req_valid) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            dp_cmd.search_step = 1'b1;
            if (dp_status.search_done) begin
               if (dp_status.match && dp_status.is_depart) begin
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SHIFT: begin
            dp_cmd.shift_step = 1'b1;
            if (dp_status.shift_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the result register to free up
            dp_cmd.finish = dp_status.out_free;
            if (dp_status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/arrival_order_departure_gate_core.sv
// arrival order departure gate: one command beat in, one result beat out, per item
// steps: accept, scan of the list, on a depart hit compaction of the entries above the hit,
//   then load of the result
// items go through one at a time
// reset (synchronous, active high) empties the list and zeroes min_occupancy and fifo_mode
// list ram contents are not cleared; only entries below the count are ever read
module arrival_order_departure_gate_core #(
   parameter int DEPTH   = 16,
   parameter int ID_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // command beats
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  aodg_pkg::cmd_type                    req_command,
   input  logic [aodg_pkg::VID_BITS-1:0]        req_vehicle_id,
   // config writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [aodg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [aodg_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   // result beats
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_allowed,
   output logic                                 rsp_found,
   output logic [aodg_pkg::POS_BITS-1:0]        rsp_position,
   output logic [aodg_pkg::OCC_BITS-1:0]        rsp_occupancy,
   output logic                                 rsp_dropped
);
   import aodg_pkg::*;

   // command and status between controller and datapath
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // controller: idle, scan, compact, finish
   aodg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // datapath: list ram, pointers, config registers and result register
   // the result register lets a new command beat in while a result still waits
   aodg_dpath #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .req_command    (req_command),
      .req_vehicle_id (req_vehicle_id),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_allowed    (rsp_allowed),
      .rsp_found      (rsp_found),
      .rsp_position   (rsp_position),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_dropped    (rsp_dropped)
   );

endmodule

>>> sv/aodg_checker.sv
// port level checker for the gate and its bind
`include "arrival_order_departure_gate_core_macros.svh"

module aodg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_allowed,
   input logic        rsp_found,
   input logic [3:0]  rsp_position,
   input logic [4:0]  rsp_occupancy,
   input logic        rsp_dropped
);

   logic [11:0] rsp_payload;

   assign rsp_payload = {rsp_allowed, rsp_found, rsp_position, rsp_occupancy, rsp_dropped};

   // a waiting result beat holds its payload
   `AODG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // reset leaves no result pending and the input open
   `AODG_ASSERT_NEXT_ALWAYS(a_reset_state, reset, !rsp_valid && req_ready)

   // one item at a time: ready drops after an accepted beat
   `AODG_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)

   // a miss reports position zero
   `AODG_ASSERT_SAME(a_miss_pos, rsp_valid && !rsp_found, rsp_position == 4'd0)

   // a dropped arrive was a miss and never grants
   `AODG_ASSERT_SAME(a_drop_miss, rsp_valid && rsp_dropped, !rsp_found && !rsp_allowed)

endmodule

bind arrival_order_departure_gate_core aodg_checker u_aodg_checker (.*);
